// ===== rtl/ms_pkg.sv =====
// ----------------------------------------------------------------------------
// ms_pkg: shared types and constants for the merge sorter
// Holds the capacity default, the sequencer states and the key compare.
// ----------------------------------------------------------------------------
package ms_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_W         = 64;

    localparam logic [KEY_W-1:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] INF_BITS = 64'h7FF0_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_RD,
        ST_MERGE,
        ST_COPY,
        ST_EMIT
    } t_state;

    function automatic logic [KEY_W-1:0] order_bits(input logic [KEY_W-1:0] x);
        order_bits = x[KEY_W-1] ? ~x : (x | {1'b1, {(KEY_W-1){1'b0}}});
    endfunction

    // numeric a <= b; -0 equals +0; false if either is NaN
    function automatic logic key_le(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b);
        logic nan_any;
        nan_any = ((a & MAG_MASK) > INF_BITS) || ((b & MAG_MASK) > INF_BITS);
        if (nan_any)
            key_le = 1'b0;
        else if (((a | b) & MAG_MASK) == '0)
            key_le = 1'b1;
        else
            key_le = order_bits(a) <= order_bits(b);
    endfunction

endpackage

// ===== rtl/merge_sorter.sv =====
// ----------------------------------------------------------------------------
// merge_sorter: stable bottom-up merge sort of double keys
// Loads keys, sorts them with one shared comparator, streams them out.
// ----------------------------------------------------------------------------
// Usage: drive i_key / i_final_item with start; a request is taken when
// start is high and busy is low. Loading takes one key per cycle. The
// request with i_final_item high closes the set and starts the sort; busy
// stays high until the last result is out. Keys beyond MAX_ITEMS are dropped
// and o_overflowed is raised on every result of that set.
// Sort: per pass, each merge pair is set up, then each element is read (ST_RD)
// and merged into scratch (ST_MERGE), then the pair is copied back to the
// store element by element (ST_COPY); passes = ceil(log2(N)). Emission then
// reads each result from the store, o_valid high for one cycle each with
// o_run_end on the last one.
// The receiver cannot stall; results must be taken as they appear.
// Reset (i_rst_n low, synchronous) empties the set and returns to loading.
// ----------------------------------------------------------------------------
module merge_sorter import ms_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_final_item,
    output logic             o_valid,
    output logic [KEY_W-1:0] o_sorted_key,
    output logic             o_run_end,
    output logic             o_overflowed
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1) + 1;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo, r_mid, n_mid, r_hi, n_hi;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic          r_ph, n_ph;

    logic             st_we, sc_we;
    logic [AW-1:0]    st_wa, st_ra, st_rb, sc_wa, sc_ra;
    logic [KEY_W-1:0] st_wd, sc_wd, st_qa, st_qb, sc_qa, sc_qb;
    logic             take_left;
    logic [CW-1:0]    hi_full;

    ms_mem #(.DEPTH(MAX_ITEMS)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_wa(st_wa), .i_wd(st_wd),
        .i_ra(st_ra), .i_rb(st_rb), .o_qa(st_qa), .o_qb(st_qb));
    ms_mem #(.DEPTH(MAX_ITEMS)) u_scratch (
        .i_clk(i_clk), .i_we(sc_we), .i_wa(sc_wa), .i_wd(sc_wd),
        .i_ra(sc_ra), .i_rb(sc_ra), .o_qa(sc_qa), .o_qb(sc_qb));

    assign hi_full   = r_lo + (r_width << 1);
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || key_le(st_qa, st_qb));
    assign busy      = (r_state != ST_LOAD);

    // next state and counters
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_ovf = r_ovf; n_width = r_width;
        n_lo = r_lo; n_mid = r_mid; n_hi = r_hi; n_i = r_i; n_j = r_j;
        n_k = r_k; n_ph = r_ph;
        case (r_state)
            ST_LOAD: begin
                if (start) begin
                    if (r_cnt < CW'(MAX_ITEMS)) n_cnt = r_cnt + 1'b1;
                    else n_ovf = 1'b1;
                    if (i_final_item) begin
                        n_state = ST_PASS;
                        n_width = CW'(1);
                        n_lo    = '0;
                    end
                end
            end
            ST_PASS: begin
                if (r_width >= r_cnt) begin
                    n_state = ST_EMIT; n_k = '0; n_ph = 1'b0;
                end else if (r_lo + r_width < r_cnt) begin
                    n_mid   = r_lo + r_width;
                    n_hi    = (hi_full > r_cnt) ? r_cnt : hi_full;
                    n_i     = r_lo; n_j = r_lo + r_width; n_k = r_lo;
                    n_state = ST_RD;
                end else begin
                    n_width = r_width << 1; n_lo = '0;
                end
            end
            ST_RD: n_state = ST_MERGE;   // wait for registered reads
            ST_MERGE: begin
                if (take_left) n_i = r_i + 1'b1;
                else n_j = r_j + 1'b1;
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_hi) begin
                    n_state = ST_COPY; n_k = r_lo; n_ph = 1'b0;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_COPY: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    n_k = r_k + 1'b1;
                    if (r_k + 1'b1 == r_hi) begin
                        n_state = ST_PASS; n_lo = hi_full;
                    end
                end
            end
            ST_EMIT: begin
                n_ph = ~r_ph;
                if (r_ph) begin
                    n_k = r_k + 1'b1;
                    if (r_k + 1'b1 == r_cnt) begin
                        n_state = ST_LOAD; n_cnt = '0; n_ovf = 1'b0;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // memory controls and outputs
    always_comb begin
        st_we = 1'b0; st_wa = r_cnt[AW-1:0]; st_wd = i_key;
        st_ra = r_i[AW-1:0]; st_rb = r_j[AW-1:0];
        sc_we = 1'b0; sc_wa = r_k[AW-1:0]; sc_wd = take_left ? st_qa : st_qb;
        sc_ra = r_k[AW-1:0];
        o_valid = 1'b0; o_run_end = 1'b0;
        o_sorted_key = st_qa; o_overflowed = r_ovf;
        case (r_state)
            ST_LOAD: st_we = start && (r_cnt < CW'(MAX_ITEMS));
            ST_MERGE: begin
                sc_we = 1'b1;
                st_ra = n_i[AW-1:0]; st_rb = n_j[AW-1:0];
            end
            ST_COPY: begin
                st_we = r_ph; st_wa = r_k[AW-1:0]; st_wd = sc_qa;
            end
            ST_EMIT: begin
                st_ra = r_k[AW-1:0];
                o_valid   = r_ph;
                o_run_end = r_ph && (r_k + 1'b1 == r_cnt);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD; r_cnt <= '0; r_ovf <= 1'b0; r_ph <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_ovf <= n_ovf; r_ph <= n_ph;
        end
        r_width <= n_width; r_lo <= n_lo; r_mid <= n_mid; r_hi <= n_hi;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
    end
endmodule

// ===== rtl/ms_mem.sv =====
// ----------------------------------------------------------------------------
// ms_mem: key store
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module ms_mem import ms_pkg::*; #(
    parameter int DEPTH = MAX_ITEMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wa,
    input  logic [KEY_W-1:0] i_wd,
    input  logic [AW-1:0]    i_ra,
    input  logic [AW-1:0]    i_rb,
    output logic [KEY_W-1:0] o_qa,
    output logic [KEY_W-1:0] o_qb
);
    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        o_qa <= mem[i_ra];
        o_qb <= mem[i_rb];
    end
endmodule
